// ===== rtl/core/rit_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rit_pkg
// Types, codes and helpers shared by the I/O and interval-timer peripheral.
// ----------------------------------------------------------------------------
package rit_pkg;

   localparam int TicksWidth = 18;

   typedef enum logic [2:0] {
      MODE_TICK   = 3'd0,
      MODE_READ   = 3'd1,
      MODE_WRITE  = 3'd2,
      MODE_PINS_A = 3'd3,
      MODE_PINS_B = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      PH_IDLE      = 2'd0,
      PH_COUNTING  = 2'd1,
      PH_FINISHING = 2'd2
   } phase_type;

   // address decode
   localparam logic [4:0] WR_DEC_MASK  = 5'h14;
   localparam logic [4:0] WR_DEC_TIMER = 5'h14;
   localparam logic [4:0] WR_DEC_EDGE  = 5'h04;
   localparam logic [4:0] RD_DEC_MASK  = 5'h05;
   localparam logic [4:0] RD_DEC_FLAGS = 5'h05;
   localparam logic [4:0] RD_DEC_TIMER = 5'h04;

   localparam int FLAG_PA7   = 0;
   localparam int FLAG_TIMER = 1;

   localparam logic [7:0]            TIMER_FULL   = 8'hff;
   localparam logic [TicksWidth-1:0] FINISH_TICKS = 18'd256;

   typedef struct packed {
      logic       tick;
      logic       load;
      logic [1:0] sel;
      logic [7:0] data;
   } timer_cmd_type;

   typedef struct packed {
      logic [7:0] value;
      logic       finishing;
      logic       expire;
   } timer_stat_type;

   typedef struct packed {
      logic [7:0] port_b_dir;
      logic [7:0] port_b_out;
      logic [7:0] port_a_dir;
      logic [7:0] port_a_out;
      logic       irq;
      logic [7:0] read_data;
   } result_type;

   function automatic logic [3:0] shift_of(input logic [1:0] sel);
      logic [3:0] s;
      case (sel)
         2'd0:    s = 4'd0;
         2'd1:    s = 4'd3;
         2'd2:    s = 4'd6;
         default: s = 4'd10;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] effective(input logic [7:0] latch,
                                            input logic [7:0] dir,
                                            input logic [7:0] pins);
      return (latch & dir) | (pins & ~dir);
   endfunction

endpackage

// ===== rtl/core/rit_timer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rit_timer
// Interval timer: prescaled countdown, then 256 single ticks after expiry.
// ----------------------------------------------------------------------------
module rit_timer (
   input  logic                   clock,
   input  logic                   reset,
   input  rit_pkg::timer_cmd_type cmd,
   output rit_pkg::timer_stat_type stat
);

   rit_pkg::phase_type                phase_ff, phase_in;
   logic [rit_pkg::TicksWidth-1:0]    ticks_ff, ticks_in;
   logic [3:0]                        shift_ff, shift_in;
   logic [rit_pkg::TicksWidth-1:0]    remain;
   logic [rit_pkg::TicksWidth-1:0]    scaled;
   logic [3:0]                        load_shift;
   logic                              expire;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rit_pkg::PH_IDLE;
         ticks_ff <= '0;
         shift_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
         shift_ff <= shift_in;
      end
   end

   assign remain     = (ticks_ff != '0) ? ticks_ff - 1'b1 : '0;
   assign scaled     = remain >> shift_ff;
   assign load_shift = rit_pkg::shift_of(cmd.sel);

   always_comb begin
      phase_in = phase_ff;
      ticks_in = ticks_ff;
      shift_in = shift_ff;
      expire   = 1'b0;
      if (cmd.load) begin
         shift_in = load_shift;
         phase_in = rit_pkg::PH_COUNTING;
         ticks_in = (rit_pkg::TicksWidth'(cmd.data) << load_shift) + 1'b1;
      end else if (cmd.tick && phase_ff != rit_pkg::PH_IDLE) begin
         if (remain != '0) begin
            ticks_in = remain;
         end else if (phase_ff == rit_pkg::PH_COUNTING) begin
            phase_in = rit_pkg::PH_FINISHING;
            ticks_in = rit_pkg::FINISH_TICKS;
            expire   = 1'b1;
         end else begin
            phase_in = rit_pkg::PH_IDLE;
            ticks_in = '0;
         end
      end
   end

   always_comb begin
      unique case (phase_ff)
         rit_pkg::PH_COUNTING:  stat.value = scaled[7:0];
         rit_pkg::PH_FINISHING: stat.value = remain[7:0];
         default:               stat.value = 8'h00;
      endcase
      stat.finishing = (phase_ff == rit_pkg::PH_FINISHING);
      stat.expire    = expire;
   end

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == rit_pkg::PH_IDLE) == (ticks_ff == '0))
      else $error("timer phase and tick count disagree");

   a_finish_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == rit_pkg::PH_FINISHING) |-> (ticks_ff <= rit_pkg::FINISH_TICKS))
      else $error("finishing count out of range");

endmodule

// ===== rtl/core/rit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rit_core
// Port registers, PA7 edge detector, interrupt flags and bus decode.
// ----------------------------------------------------------------------------
module rit_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  rit_pkg::mode_type   mode,
   input  logic [4:0]          offset,
   input  logic [7:0]          data,
   input  logic [7:0]          mask,
   output rit_pkg::result_type result
);

   logic [7:0] pins_a_ff, pins_a_in, pins_b_ff, pins_b_in;
   logic [7:0] latch_a_ff, latch_a_in, latch_b_ff, latch_b_in;
   logic [7:0] dir_a_ff, dir_a_in, dir_b_ff, dir_b_in;
   logic [1:0] flag_ff, flag_in, enable_ff, enable_in;
   logic       edge_ff, edge_in, last_pa7_ff, last_pa7_in;
   logic [7:0] rd;
   logic       chk_pa7;
   logic [7:0] pa_view;
   logic       level;
   logic       keep_tflag;

   rit_pkg::timer_cmd_type  tcmd;
   rit_pkg::timer_stat_type tstat;

   rit_timer u_timer (
      .clock (clock),
      .reset (reset),
      .cmd   (tcmd),
      .stat  (tstat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pins_a_ff   <= '0;
         pins_b_ff   <= '0;
         latch_a_ff  <= '0;
         latch_b_ff  <= '0;
         dir_a_ff    <= '0;
         dir_b_ff    <= '0;
         flag_ff     <= '0;
         enable_ff   <= '0;
         edge_ff     <= 1'b0;
         last_pa7_ff <= 1'b0;
      end else begin
         pins_a_ff   <= pins_a_in;
         pins_b_ff   <= pins_b_in;
         latch_a_ff  <= latch_a_in;
         latch_b_ff  <= latch_b_in;
         dir_a_ff    <= dir_a_in;
         dir_b_ff    <= dir_b_in;
         flag_ff     <= flag_in;
         enable_ff   <= enable_in;
         edge_ff     <= edge_in;
         last_pa7_ff <= last_pa7_in;
      end
   end

   always_comb begin
      tcmd      = '0;
      tcmd.sel  = offset[1:0];
      tcmd.data = data;
      if (go) begin
         tcmd.tick = (mode == rit_pkg::MODE_TICK);
         tcmd.load = (mode == rit_pkg::MODE_WRITE) &&
                     ((offset & rit_pkg::WR_DEC_MASK) == rit_pkg::WR_DEC_TIMER);
      end
   end

   assign keep_tflag = tstat.finishing && (tstat.value == rit_pkg::TIMER_FULL);

   always_comb begin
      pins_a_in   = pins_a_ff;
      pins_b_in   = pins_b_ff;
      latch_a_in  = latch_a_ff;
      latch_b_in  = latch_b_ff;
      dir_a_in    = dir_a_ff;
      dir_b_in    = dir_b_ff;
      flag_in     = flag_ff;
      enable_in   = enable_ff;
      edge_in     = edge_ff;
      last_pa7_in = last_pa7_ff;
      rd          = 8'h00;
      chk_pa7     = 1'b0;
      if (go) begin
         unique case (mode)
            rit_pkg::MODE_READ: begin
               if ((offset & rit_pkg::RD_DEC_MASK) == rit_pkg::RD_DEC_FLAGS) begin
                  rd = {flag_ff[rit_pkg::FLAG_TIMER], flag_ff[rit_pkg::FLAG_PA7], 6'b0};
                  flag_in[rit_pkg::FLAG_PA7] = 1'b0;
               end else if ((offset & rit_pkg::RD_DEC_MASK) == rit_pkg::RD_DEC_TIMER) begin
                  rd = tstat.value;
                  enable_in[rit_pkg::FLAG_TIMER] = offset[3];
                  if (!keep_tflag) begin
                     flag_in[rit_pkg::FLAG_TIMER] = 1'b0;
                  end
               end else if (offset[1]) begin
                  rd = offset[0] ? dir_b_ff : rit_pkg::effective(latch_b_ff, dir_b_ff, pins_b_ff);
               end else begin
                  rd = offset[0] ? dir_a_ff : rit_pkg::effective(latch_a_ff, dir_a_ff, pins_a_ff);
               end
            end
            rit_pkg::MODE_WRITE: begin
               if ((offset & rit_pkg::WR_DEC_MASK) == rit_pkg::WR_DEC_TIMER) begin
                  enable_in[rit_pkg::FLAG_TIMER] = offset[3];
                  if (!keep_tflag) begin
                     flag_in[rit_pkg::FLAG_TIMER] = 1'b0;
                  end
               end else if ((offset & rit_pkg::WR_DEC_MASK) == rit_pkg::WR_DEC_EDGE) begin
                  enable_in[rit_pkg::FLAG_PA7] = offset[1];
                  edge_in = offset[0];
               end else if (offset[1]) begin
                  if (offset[0]) begin
                     dir_b_in = data;
                  end else begin
                     latch_b_in = data;
                  end
               end else begin
                  if (offset[0]) begin
                     dir_a_in = data;
                  end else begin
                     latch_a_in = data;
                  end
                  chk_pa7 = 1'b1;
               end
            end
            rit_pkg::MODE_PINS_A: begin
               pins_a_in = (pins_a_ff & ~mask) | (data & mask);
               chk_pa7   = 1'b1;
            end
            rit_pkg::MODE_PINS_B: begin
               pins_b_in = (pins_b_ff & ~mask) | (data & mask);
            end
            default: ;
         endcase
      end
      if (tstat.expire) begin
         flag_in[rit_pkg::FLAG_TIMER] = 1'b1;
      end
      pa_view = rit_pkg::effective(latch_a_in, dir_a_in, pins_a_in);
      level   = pa_view[7];
      if (chk_pa7) begin
         if (level != last_pa7_ff && level == edge_ff) begin
            flag_in[rit_pkg::FLAG_PA7] = 1'b1;
         end
         last_pa7_in = level;
      end
   end

   always_comb begin
      result.read_data  = rd;
      result.irq        = |(flag_in & enable_in);
      result.port_a_out = latch_a_in;
      result.port_a_dir = dir_a_in;
      result.port_b_out = latch_b_in;
      result.port_b_dir = dir_b_in;
   end

   a_expire_flag: assert property (@(posedge clock) disable iff (reset)
      tstat.expire |=> flag_ff[rit_pkg::FLAG_TIMER])
      else $error("timer expiry did not raise the timer flag");

endmodule

// ===== rtl/core/ram_io_timer_peripheral_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ram_io_timer_peripheral_top
// Two-port I/O and interval-timer peripheral with stream interfaces.
// ----------------------------------------------------------------------------
// Takes one item per clock while req_tready is high and returns exactly one
// result per item: an input register feeds the decode and state update, whose
// outcome lands in the result register. All state changes for an item happen
// as it moves from the input register, so a new item may follow every cycle;
// while a result waits for rsp_tready the input register still holds one
// item, and req_tready drops only once both registers are full.
module ram_io_timer_peripheral_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // offset[4:0], data[12:5], mask[20:13], zero pad
   input  logic [2:0]  req_tuser,   // mode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // read_data[7:0], irq[8], port_a_out[16:9],
                                    // port_a_dir[24:17], port_b_out[32:25],
                                    // port_b_dir[40:33], zero pad
);

   logic                in_valid_ff, in_valid_in;
   rit_pkg::mode_type   in_mode_ff;
   logic [4:0]          in_offset_ff;
   logic [7:0]          in_data_ff, in_mask_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rit_pkg::result_type rsp_ff, result;
   logic                advance, req_fire;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_mode_ff   <= rit_pkg::mode_type'(req_tuser);
         in_offset_ff <= req_tdata[4:0];
         in_data_ff   <= req_tdata[12:5];
         in_mask_ff   <= req_tdata[20:13];
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   rit_core u_core (
      .clock  (clock),
      .reset  (reset),
      .go     (advance),
      .mode   (in_mode_ff),
      .offset (in_offset_ff),
      .data   (in_data_ff),
      .mask   (in_mask_ff),
      .result (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_ff.port_b_dir, rsp_ff.port_b_out, rsp_ff.port_a_dir,
                        rsp_ff.port_a_out, rsp_ff.irq, rsp_ff.read_data};

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled while the pipeline has room");

endmodule

// ===== tb/tb_ram_io_timer_peripheral_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ram_io_timer_peripheral_top
// Self-checking bench for the I/O and interval-timer peripheral. Items go in
// over the request stream with random gaps. Each result is checked field by
// field against an in-bench model of the ports, the PA7 edge detector, the
// interrupt flags and the timer. The response side stalls at random. The
// stimulus covers directed port, edge and timer cases, mixed random traffic
// and long timer runs through expiry and the finishing count.
// ----------------------------------------------------------------------------
module tb_ram_io_timer_peripheral_top;

   localparam int         CYCLE_LIMIT     = 500000;
   localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

   localparam logic [4:0] ADDR_PA_LATCH = 5'h00;
   localparam logic [4:0] ADDR_PA_DIR   = 5'h01;
   localparam logic [4:0] ADDR_PB_LATCH = 5'h02;
   localparam logic [4:0] ADDR_PB_DIR   = 5'h03;
   localparam logic [4:0] ADDR_PORT_B   = 5'h02;
   localparam logic [4:0] ADDR_DIR      = 5'h01;
   localparam logic [4:0] ADDR_EDGE_EN  = 5'h02;
   localparam logic [4:0] ADDR_EDGE_UP  = 5'h01;
   localparam logic [4:0] ADDR_IRQ_EN   = 5'h08;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // offset[4:0], data[12:5], mask[20:13], zero pad
   logic [2:0]  req_tuser  = '0;   // mode[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // read_data[7:0], irq[8], port_a_out[16:9],
                                   // port_a_dir[24:17], port_b_out[32:25],
                                   // port_b_dir[40:33], zero pad

   ram_io_timer_peripheral_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // peripheral state as predicted
   logic [7:0]                     pa_pins  = '0;
   logic [7:0]                     pb_pins  = '0;
   logic [7:0]                     pa_latch = '0;
   logic [7:0]                     pb_latch = '0;
   logic [7:0]                     pa_dir   = '0;
   logic [7:0]                     pb_dir   = '0;
   logic [1:0]                     flags    = '0;
   logic [1:0]                     enables  = '0;
   logic                           edge_up  = 1'b0;
   logic                           pa7_seen = 1'b0;
   logic [3:0]                     shift    = '0;
   rit_pkg::phase_type             phase    = rit_pkg::PH_IDLE;
   logic [rit_pkg::TicksWidth-1:0] ticks    = '0;

   rit_pkg::result_type riot_expected[$];

   int  items_sent      = 0;
   int  results_checked = 0;
   int  mismatches      = 0;
   int  cycles          = 0;
   int  stall_left      = 0;
   bit  tx_gaps_on      = 1'b1;
   bit  rx_stalls_on    = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] pin_view(input logic [7:0] latch, input logic [7:0] dir,
                                           input logic [7:0] pins);
      return (latch & dir) | (pins & ~dir);
   endfunction

   function automatic logic [7:0] timer_reading();
      logic [rit_pkg::TicksWidth-1:0] left;
      logic [rit_pkg::TicksWidth-1:0] scaled;
      left = (ticks != 0) ? ticks - 1'b1 : '0;
      scaled = left >> shift;
      if (phase == rit_pkg::PH_COUNTING) return scaled[7:0];
      if (phase == rit_pkg::PH_FINISHING) return left[7:0];
      return 8'h00;
   endfunction

   task automatic drop_timer_flag(input logic [7:0] shown);
      if (phase != rit_pkg::PH_FINISHING || shown != rit_pkg::TIMER_FULL)
         flags[rit_pkg::FLAG_TIMER] = 1'b0;
   endtask

   task automatic pa7_watch();
      logic [7:0] level;
      level = pin_view(pa_latch, pa_dir, pa_pins);
      if (level[7] != pa7_seen && level[7] == edge_up) flags[rit_pkg::FLAG_PA7] = 1'b1;
      pa7_seen = level[7];
   endtask

   task automatic riot_tick();
      if (phase != rit_pkg::PH_IDLE) begin
         if (ticks != 0) ticks = ticks - 1'b1;
         if (ticks == 0) begin
            if (phase == rit_pkg::PH_COUNTING) begin
               phase = rit_pkg::PH_FINISHING;
               ticks = rit_pkg::FINISH_TICKS;
               flags[rit_pkg::FLAG_TIMER] = 1'b1;
            end else begin
               phase = rit_pkg::PH_IDLE;
            end
         end
      end
   endtask

   task automatic riot_read(input logic [4:0] off, output logic [7:0] rd);
      if ((off & rit_pkg::RD_DEC_MASK) == rit_pkg::RD_DEC_FLAGS) begin
         rd = {flags[rit_pkg::FLAG_TIMER], flags[rit_pkg::FLAG_PA7], 6'b000000};
         flags[rit_pkg::FLAG_PA7] = 1'b0;
      end else if ((off & rit_pkg::RD_DEC_MASK) == rit_pkg::RD_DEC_TIMER) begin
         rd = timer_reading();
         enables[rit_pkg::FLAG_TIMER] = (off & ADDR_IRQ_EN) != 0;
         drop_timer_flag(rd);
      end else if ((off & ADDR_PORT_B) != 0) begin
         rd = ((off & ADDR_DIR) != 0) ? pb_dir : pin_view(pb_latch, pb_dir, pb_pins);
      end else begin
         rd = ((off & ADDR_DIR) != 0) ? pa_dir : pin_view(pa_latch, pa_dir, pa_pins);
      end
   endtask

   task automatic riot_write(input logic [4:0] off, input logic [7:0] data);
      logic [rit_pkg::TicksWidth-1:0] span;
      if ((off & rit_pkg::WR_DEC_MASK) == rit_pkg::WR_DEC_TIMER) begin
         case (off[1:0])
            2'd0:    shift = 4'd0;
            2'd1:    shift = 4'd3;
            2'd2:    shift = 4'd6;
            default: shift = 4'd10;
         endcase
         enables[rit_pkg::FLAG_TIMER] = (off & ADDR_IRQ_EN) != 0;
         drop_timer_flag(timer_reading());
         phase = rit_pkg::PH_COUNTING;
         span  = rit_pkg::TicksWidth'(data);
         ticks = (span << shift) + 1'b1;
      end else if ((off & rit_pkg::WR_DEC_MASK) == rit_pkg::WR_DEC_EDGE) begin
         enables[rit_pkg::FLAG_PA7] = (off & ADDR_EDGE_EN) != 0;
         edge_up = (off & ADDR_EDGE_UP) != 0;
      end else if ((off & ADDR_PORT_B) != 0) begin
         if ((off & ADDR_DIR) != 0) pb_dir = data;
         else pb_latch = data;
      end else begin
         if ((off & ADDR_DIR) != 0) pa_dir = data;
         else pa_latch = data;
         pa7_watch();
      end
   endtask

   task automatic riot_step(input logic [2:0] mode, input logic [4:0] off,
                            input logic [7:0] data, input logic [7:0] mask);
      rit_pkg::result_type want;
      logic [7:0] rd;
      rd = 8'h00;
      case (mode)
         rit_pkg::MODE_TICK:   riot_tick();
         rit_pkg::MODE_READ:   riot_read(off, rd);
         rit_pkg::MODE_WRITE:  riot_write(off, data);
         rit_pkg::MODE_PINS_A: begin
            pa_pins = (pa_pins & ~mask) | (data & mask);
            pa7_watch();
         end
         rit_pkg::MODE_PINS_B: pb_pins = (pb_pins & ~mask) | (data & mask);
         default: ;
      endcase
      want.read_data  = rd;
      want.irq        = |(flags & enables);
      want.port_a_out = pa_latch;
      want.port_a_dir = pa_dir;
      want.port_b_out = pb_latch;
      want.port_b_dir = pb_dir;
      riot_expected.push_back(want);
   endtask

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   task automatic check_result(input rit_pkg::result_type got);
      rit_pkg::result_type want;
      if (riot_expected.size() == 0) begin
         report_mismatch("result with no item outstanding");
      end else begin
         want = riot_expected.pop_front();
         results_checked++;
         if (got.read_data !== want.read_data)
            report_mismatch($sformatf("result %0d read_data %h, want %h",
                                      results_checked, got.read_data, want.read_data));
         if (got.irq !== want.irq)
            report_mismatch($sformatf("result %0d irq %b, want %b",
                                      results_checked, got.irq, want.irq));
         if (got.port_a_out !== want.port_a_out)
            report_mismatch($sformatf("result %0d port_a_out %h, want %h",
                                      results_checked, got.port_a_out, want.port_a_out));
         if (got.port_a_dir !== want.port_a_dir)
            report_mismatch($sformatf("result %0d port_a_dir %h, want %h",
                                      results_checked, got.port_a_dir, want.port_a_dir));
         if (got.port_b_out !== want.port_b_out)
            report_mismatch($sformatf("result %0d port_b_out %h, want %h",
                                      results_checked, got.port_b_out, want.port_b_out));
         if (got.port_b_dir !== want.port_b_dir)
            report_mismatch($sformatf("result %0d port_b_dir %h, want %h",
                                      results_checked, got.port_b_dir, want.port_b_dir));
      end
   endtask

   // check accepted results, then pick the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_result(rit_pkg::result_type'(rsp_tdata[40:0]));
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 9) == 0) begin
         stall_left <= pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_item(input logic [2:0] mode, input logic [4:0] off,
                            input logic [7:0] data, input logic [7:0] mask);
      int gap;
      gap = tx_gaps_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {3'b000, mask, data, off};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      riot_step(mode, off, data, mask);
      items_sent++;
   endtask

   // hold the request side until every result is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (riot_expected.size() != 0) @(posedge clock);
   endtask

   task automatic test_ports();
      send_item(rit_pkg::MODE_WRITE, ADDR_PA_DIR, 8'hff, 8'h00);
      send_item(rit_pkg::MODE_WRITE, ADDR_PA_LATCH, 8'h00, 8'hff);
      send_item(rit_pkg::MODE_PINS_A, ADDR_PA_LATCH, 8'hff, 8'hff);
      send_item(rit_pkg::MODE_READ, ADDR_PA_LATCH, 8'h00, 8'h00);
      send_item(rit_pkg::MODE_WRITE, ADDR_PB_DIR, 8'h0f, 8'h00);
      send_item(rit_pkg::MODE_WRITE, ADDR_PB_LATCH, 8'hff, 8'h00);
      send_item(rit_pkg::MODE_PINS_B, ADDR_PB_LATCH, 8'h5a, 8'hf0);
      send_item(rit_pkg::MODE_READ, ADDR_PB_LATCH, 8'h00, 8'h00);
      send_item(rit_pkg::MODE_READ, ADDR_PB_DIR | 5'h18, 8'h00, 8'h00);
   endtask

   task automatic test_pa7_edge();
      send_item(rit_pkg::MODE_WRITE, rit_pkg::WR_DEC_EDGE | ADDR_EDGE_EN | ADDR_EDGE_UP,
                8'h00, 8'h00);
      send_item(rit_pkg::MODE_WRITE, ADDR_PA_DIR, 8'h00, 8'h00);
      send_item(rit_pkg::MODE_READ, rit_pkg::RD_DEC_FLAGS, 8'h00, 8'h00);
      send_item(rit_pkg::MODE_PINS_A, ADDR_PA_LATCH, 8'h00, 8'h80);
      send_item(rit_pkg::MODE_WRITE, rit_pkg::WR_DEC_EDGE | ADDR_EDGE_EN, 8'h00, 8'h00);
      send_item(rit_pkg::MODE_PINS_A, ADDR_PA_LATCH, 8'h80, 8'h80);
      send_item(rit_pkg::MODE_PINS_A, ADDR_PA_LATCH, 8'h00, 8'h80);
      send_item(rit_pkg::MODE_READ, rit_pkg::RD_DEC_FLAGS | 5'h1a, 8'h00, 8'h00);
   endtask

   task automatic test_timer();
      send_item(rit_pkg::MODE_TICK, '0, 8'h00, 8'h00);
      send_item(rit_pkg::MODE_WRITE, rit_pkg::WR_DEC_TIMER | ADDR_IRQ_EN, 8'h00, 8'h00);
      send_item(rit_pkg::MODE_TICK, '0, 8'h00, 8'h00);
      send_item(rit_pkg::MODE_READ, rit_pkg::RD_DEC_TIMER | ADDR_IRQ_EN, 8'h00, 8'h00);
      send_item(rit_pkg::MODE_READ, rit_pkg::RD_DEC_FLAGS, 8'h00, 8'h00);
      send_item(rit_pkg::MODE_WRITE, rit_pkg::WR_DEC_TIMER | ADDR_IRQ_EN | 5'd2,
                8'h01, 8'h00);
      send_item(rit_pkg::MODE_READ, rit_pkg::RD_DEC_TIMER, 8'h00, 8'h00);
      send_item(rit_pkg::MODE_WRITE, rit_pkg::WR_DEC_TIMER | 5'd3, 8'hff, 8'h00);
      send_item(rit_pkg::MODE_READ, rit_pkg::RD_DEC_TIMER | ADDR_IRQ_EN, 8'h00, 8'h00);
      send_item(rit_pkg::MODE_WRITE, rit_pkg::WR_DEC_TIMER | 5'd1, 8'h80, 8'h00);
   endtask

   task automatic test_spare_modes();
      send_item(MODE_SPARE_FIRST, 5'h1f, 8'hff, 8'hff);
      send_item(MODE_SPARE_LAST, 5'h1f, 8'hff, 8'hff);
   endtask

   task automatic send_random_item();
      int         r;
      logic [4:0] off;
      logic [7:0] data;
      logic [7:0] mask;
      logic [1:0] sel;
      r    = $urandom_range(0, 99);
      off  = 5'($urandom_range(0, 31));
      data = 8'($urandom_range(0, 255));
      mask = 8'($urandom_range(0, 255));
      if (r < 50) begin
         send_item(rit_pkg::MODE_TICK, off, data, mask);
      end else if (r < 62) begin
         send_item(rit_pkg::MODE_READ, off, data, mask);
      end else if (r < 74) begin
         send_item(rit_pkg::MODE_WRITE, off & ~rit_pkg::WR_DEC_EDGE, data, mask);
      end else if (r < 80) begin
         send_item(rit_pkg::MODE_WRITE, (off & ~rit_pkg::WR_DEC_MASK) | rit_pkg::WR_DEC_EDGE,
                   data, mask);
      end else if (r < 83) begin
         // keep most loads short so the timer expires now and then
         sel = 2'($urandom_range(0, 3));
         if (sel >= 2'd2) data = 8'($urandom_range(0, 3));
         else if ($urandom_range(0, 3) != 0) data = 8'($urandom_range(0, 40));
         send_item(rit_pkg::MODE_WRITE,
                   (off & ~5'h03) | rit_pkg::WR_DEC_TIMER | {3'b000, sel}, data, mask);
      end else if (r < 92) begin
         send_item(rit_pkg::MODE_PINS_A, off, data, mask);
      end else if (r < 98) begin
         send_item(rit_pkg::MODE_PINS_B, off, data, mask);
      end else begin
         send_item(3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)), off, data, mask);
      end
   endtask

   task automatic test_random_mix(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) begin
            tx_gaps_on   = $urandom_range(0, 9) < 7;
            rx_stalls_on = $urandom_range(0, 9) < 7;
         end
         send_random_item();
      end
   endtask

   // load a short count and tick well past expiry and the finishing count
   task automatic test_timer_run();
      int         ticks_sent;
      int         r;
      logic [4:0] off;
      ticks_sent = 0;
      off = rit_pkg::WR_DEC_TIMER | {4'b0000, 1'($urandom_range(0, 1))};
      if ($urandom_range(0, 1) != 0) off = off | ADDR_IRQ_EN;
      send_item(rit_pkg::MODE_WRITE, off, 8'($urandom_range(0, 4)),
                8'($urandom_range(0, 255)));
      while (ticks_sent < 300) begin
         r   = $urandom_range(0, 99);
         off = 5'($urandom_range(0, 31));
         if (r < 82) begin
            send_item(rit_pkg::MODE_TICK, off, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
            ticks_sent++;
         end else if (r < 92) begin
            send_item(rit_pkg::MODE_READ, (off & ~rit_pkg::RD_DEC_MASK) | rit_pkg::RD_DEC_TIMER,
                      8'h00, 8'h00);
         end else if (r < 96) begin
            send_item(rit_pkg::MODE_READ, off | rit_pkg::RD_DEC_FLAGS, 8'h00, 8'h00);
         end else begin
            send_random_item();
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_ports();
      test_pa7_edge();
      test_timer();
      test_spare_modes();
      test_random_mix(220);
      test_timer_run();
      drain_results();
      test_random_mix(200);
      tx_gaps_on   = 1'b0;
      rx_stalls_on = 1'b0;
      test_timer_run();

      drain_results();
      repeat (10) @(posedge clock);

      $display("Sent %0d items: port and direction access, PA7 edges both ways, spare modes,",
               items_sent);
      $display("timer loads at every prescale through expiry and the finishing count; %0d checked",
               results_checked);
      if (mismatches == 0 && riot_expected.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
